// ===== hw/rtl/cosine_best_match_search_top_defines.svh =====
// ----------------------------------------------------------------------------
// cosine best-match search assertion macros
// shared concurrent assertion forms for the search block
// ----------------------------------------------------------------------------
`ifndef COSINE_BEST_MATCH_SEARCH_TOP_DEFINES_SVH
`define COSINE_BEST_MATCH_SEARCH_TOP_DEFINES_SVH

// same-cycle implication
`define CBMS_ASSERT_IMP(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBMS_ASSERT_NXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cbms_pkg.sv =====
// ----------------------------------------------------------------------------
// cosine best-match search package
// word types, controller states, command and status groups, constants
// ----------------------------------------------------------------------------
`default_nettype none

package cbms_pkg;

  localparam int MAX_VECTORS = 1024;
  localparam int CNT_W       = $clog2(MAX_VECTORS + 1);
  localparam int COMP_W      = 16;
  localparam int IDX_W       = 10;
  localparam int SCORE_W     = 15;
  localparam int NORM_W      = 32;
  localparam int DOT_W       = 34;
  localparam int RAD_W       = 64;
  localparam int QUO_W       = 16;
  localparam int STEP_W      = 4;
  localparam int MAC_CYCLES  = 10;
  localparam int DIV_CYCLES  = 16;

  localparam logic [RAD_W-1:0]   SQRT_TOP  = 64'h4000_0000_0000_0000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_QUERY_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_Z = 2'd2;

  typedef struct packed {
    logic signed [COMP_W-1:0] vec_x;
    logic signed [COMP_W-1:0] vec_y;
    logic signed [COMP_W-1:0] vec_z;
    logic                     last_vector;
  } vec_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   best_index;
    logic [SCORE_W-1:0] best_score;
    logic               too_many;
  } res_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_NORM,
    ST_SQRT,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic count;
    logic set_overflow;
    logic mac;
    logic norm;
    logic sqrt;
    logic div;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic run_full;
    logic mac_last;
    logic scorable;
    logic sqrt_last;
    logic div_last;
    logic last_item;
    logic slot_full;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cbms_ctrl.sv =====
// ----------------------------------------------------------------------------
// cosine best-match search controller
// sequences accept, multiply-accumulate, norm, square root, divide, update and result
// ----------------------------------------------------------------------------
`default_nettype none

module cbms_ctrl
  import cbms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    vec_valid,
  output logic    vec_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (vec_valid) begin
          state_next = sts.run_full ? ST_FINISH : ST_MAC;
        end
      end
      ST_MAC: begin
        if (sts.mac_last) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        state_next = sts.scorable ? ST_SQRT : ST_FINISH;
      end
      ST_SQRT: begin
        if (sts.sqrt_last) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.last_item || !sts.slot_full) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    vec_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        vec_ready = 1'b1;
        if (vec_valid) begin
          cmd.load         = 1'b1;
          cmd.count        = !sts.run_full;
          cmd.set_overflow = sts.run_full;
        end
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
      end
      ST_NORM: begin
        cmd.norm = 1'b1;
      end
      ST_SQRT: begin
        cmd.sqrt = 1'b1;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      ST_FINISH: begin
        cmd.emit = sts.last_item && !sts.slot_full;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cbms_dp.sv =====
// ----------------------------------------------------------------------------
// cosine best-match search datapath
// shared multiplier, norm product, bit-serial square root, restoring divider
// ----------------------------------------------------------------------------
`default_nettype none

module cbms_dp
  import cbms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  vec_word_t                vec_word,
  input  logic signed [COMP_W-1:0] query_x,
  input  logic signed [COMP_W-1:0] query_y,
  input  logic signed [COMP_W-1:0] query_z,
  input  cmd_t                     cmd,
  output status_t                  sts,
  output logic                     res_valid,
  input  logic                     res_ready,
  output res_word_t                res_word
);

  logic signed [COMP_W-1:0]   vx;
  logic signed [COMP_W-1:0]   vy;
  logic signed [COMP_W-1:0]   vz;
  logic                       last_item;
  logic [IDX_W-1:0]           pos;
  logic [STEP_W-1:0]          step;
  logic signed [2*COMP_W-1:0] prod;
  logic [NORM_W-1:0]          vn;
  logic [NORM_W-1:0]          qn;
  logic signed [DOT_W-1:0]    dot;
  logic [RAD_W-1:0]           rad;
  logic [RAD_W-1:0]           root;
  logic [RAD_W-1:0]           sbit;
  logic [NORM_W:0]            rem;
  logic [QUO_W-1:0]           quo;
  logic [CNT_W-1:0]           run_count;
  logic [IDX_W-1:0]           best_index;
  logic [SCORE_W-1:0]         best_score;
  logic                       overflow;

  logic signed [COMP_W-1:0]   op_a;
  logic signed [COMP_W-1:0]   op_b;
  logic [RAD_W-1:0]           norm_prod;
  logic [RAD_W-1:0]           trial;
  logic [NORM_W:0]            den;
  logic [NORM_W:0]            rem_sub;
  logic                       qbit;
  logic [SCORE_W-1:0]         score;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      4'd0: begin op_a = vx;      op_b = vx;      end
      4'd1: begin op_a = vy;      op_b = vy;      end
      4'd2: begin op_a = vz;      op_b = vz;      end
      4'd3: begin op_a = query_x; op_b = query_x; end
      4'd4: begin op_a = query_y; op_b = query_y; end
      4'd5: begin op_a = query_z; op_b = query_z; end
      4'd6: begin op_a = vx;      op_b = query_x; end
      4'd7: begin op_a = vy;      op_b = query_y; end
      4'd8: begin op_a = vz;      op_b = query_z; end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign norm_prod = {{(RAD_W-NORM_W){1'b0}}, vn} * {{(RAD_W-NORM_W){1'b0}}, qn};
  assign trial     = root + sbit;
  assign den       = {1'b0, root[NORM_W-1:0]};
  assign qbit      = (rem >= den);
  assign rem_sub   = qbit ? (rem - den) : rem;
  assign score     = quo[QUO_W-1] ? SCORE_MAX : quo[SCORE_W-1:0];

  assign sts.run_full  = (run_count == CNT_W'(MAX_VECTORS));
  assign sts.mac_last  = (step == STEP_W'(MAC_CYCLES - 1));
  assign sts.scorable  = (vn != '0) && (qn != '0) && !dot[DOT_W-1] && (dot != '0);
  assign sts.sqrt_last = sbit[0];
  assign sts.div_last  = (step == STEP_W'(DIV_CYCLES - 1));
  assign sts.last_item = last_item;
  assign sts.slot_full = res_valid;

  // item registers and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx        <= vec_word.vec_x;
      vy        <= vec_word.vec_y;
      vz        <= vec_word.vec_z;
      last_item <= vec_word.last_vector;
      pos       <= IDX_W'(run_count);
      step      <= '0;
      vn        <= '0;
      qn        <= '0;
      dot       <= '0;
    end
    if (cmd.mac) begin
      prod <= (2*COMP_W)'(op_a) * (2*COMP_W)'(op_b);
      step <= step + 1'b1;
      case (step)
        4'd1, 4'd2, 4'd3: vn  <= vn + $unsigned(prod);
        4'd4, 4'd5, 4'd6: qn  <= qn + $unsigned(prod);
        4'd7, 4'd8, 4'd9: dot <= dot + DOT_W'(prod);
        default: ;
      endcase
    end
    if (cmd.norm) begin
      rad  <= norm_prod;
      root <= '0;
      sbit <= SQRT_TOP;
      rem  <= {1'b0, dot[NORM_W-1:0]};
      quo  <= '0;
      step <= '0;
    end
    if (cmd.sqrt) begin
      if (rad >= trial) begin
        rad  <= rad - trial;
        root <= (root >> 1) + sbit;
      end else begin
        root <= root >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (cmd.div) begin
      rem  <= {rem_sub[NORM_W-1:0], 1'b0};
      quo  <= {quo[QUO_W-2:0], qbit};
      step <= step + 1'b1;
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_count  <= '0;
      best_index <= '0;
      best_score <= '0;
      overflow   <= 1'b0;
    end else if (cmd.emit) begin
      run_count  <= '0;
      best_index <= '0;
      best_score <= '0;
      overflow   <= 1'b0;
    end else begin
      if (cmd.count) begin
        run_count <= run_count + 1'b1;
      end
      if (cmd.set_overflow) begin
        overflow <= 1'b1;
      end
      if (cmd.update && (score > best_score)) begin
        best_score <= score;
        best_index <= pos;
      end
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_word.best_index <= best_index;
      res_word.best_score <= best_score;
      res_word.too_many   <= overflow;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cosine_best_match_search_top.sv =====
// ----------------------------------------------------------------------------
// cosine best-match search top level
// query registers on apb, controller and datapath for the candidate stream
//
//   channel   handshake            word
//   vec       vec_valid/vec_ready  vec_word_t: vec_x, vec_y, vec_z, last_vector
//   res       res_valid/res_ready  res_word_t: best_index, best_score, too_many
//   apb       psel/penable/pready  query_x, query_y, query_z at 0x0, 0x4, 0x8
//
// a scored candidate passes through accept, the shared 16x16 multiplier, the
// 32x32 norm product, the bit-serial square root, the restoring divider,
// update and finish; an unscored one goes from the norm product to finish
// the last word waits in finish while the result slot still holds a word
// reset is synchronous and clears the run state, query registers and result
// ----------------------------------------------------------------------------
`default_nettype none

`include "cosine_best_match_search_top_defines.svh"

module cosine_best_match_search_top
  import cbms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               vec_valid,
  output logic               vec_ready,
  input  vec_word_t          vec_word,
  output logic               res_valid,
  input  logic               res_ready,
  output res_word_t          res_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic signed [COMP_W-1:0] query_x;
  logic signed [COMP_W-1:0] query_y;
  logic signed [COMP_W-1:0] query_z;
  logic [REG_IDX_W-1:0]     reg_idx;
  cmd_t                     cmd;
  status_t                  sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
      query_z <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_QUERY_X: query_x <= pwdata[COMP_W-1:0];
        REG_QUERY_Y: query_y <= pwdata[COMP_W-1:0];
        REG_QUERY_Z: query_z <= pwdata[COMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_QUERY_X: prdata = PDATA_W'(query_x);
      REG_QUERY_Y: prdata = PDATA_W'(query_y);
      REG_QUERY_Z: prdata = PDATA_W'(query_z);
      default:     prdata = '0;
    endcase
  end

  cbms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .vec_valid (vec_valid),
    .vec_ready (vec_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbms_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .vec_word  (vec_word),
    .query_x   (query_x),
    .query_y   (query_y),
    .query_z   (query_z),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  `CBMS_ASSERT_NXT(a_one_in_flight, clk, rst, vec_valid && vec_ready, !vec_ready, "second word taken while busy")
  `CBMS_ASSERT_IMP(a_emit_free, clk, rst, cmd.emit, !sts.slot_full, "result slot overwritten")
  `CBMS_ASSERT_NXT(a_div_to_update, clk, rst, cmd.div && sts.div_last, cmd.update, "divide did not end in update")
  `CBMS_ASSERT_IMP(a_count_sat, clk, rst, sts.run_full, !cmd.count, "vector count past limit")

endmodule

`default_nettype wire

// ===== tb/cosine_best_match_search_top_test.sv =====
// ----------------------------------------------------------------------------
// cosine best-match search testbench
// writes query settings over apb, streams runs of candidate words with random
// gaps and output stalls, predicts best index, score and overflow of each run
// and checks every result word in order
// ----------------------------------------------------------------------------
module cosine_best_match_search_top_test;
  import cbms_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int MAX_GAP      = 18;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               vec_valid = 1'b0;
  logic               vec_ready;
  vec_word_t          vec_word = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  res_word_t          res_word;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  cosine_best_match_search_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .vec_valid (vec_valid),
    .vec_ready (vec_ready),
    .vec_word  (vec_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [COMP_W-1:0] q_x = '0;
  logic signed [COMP_W-1:0] q_y = '0;
  logic signed [COMP_W-1:0] q_z = '0;
  int                       run_len = 0;
  logic [IDX_W-1:0]         run_best_idx = '0;
  logic [SCORE_W-1:0]       run_best_score = '0;
  logic                     run_overflow = 1'b0;
  res_word_t                pending_best[$];

  int   errors = 0;
  int   words_sent = 0;
  int   results_checked = 0;
  int   overflow_results = 0;
  int   saturated_results = 0;
  int   query_settings = 0;
  int   cycle_count = 0;
  int   next_gap = 0;
  bit   vec_idle_on = 1'b1;
  logic res_idle_on = 1'b1;
  logic hold_on = 1'b0;

  function automatic int draw_gap(input bit on);
    return on ? int'($urandom_range(0, MAX_GAP)) : 0;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned one;
    root = 0;
    rem  = x;
    one  = 64'h4000_0000_0000_0000;
    while (one > rem) one = one >> 2;
    while (one != 0) begin
      if (rem >= root + one) begin
        rem  = rem - (root + one);
        root = (root >> 1) + one;
      end else begin
        root = root >> 1;
      end
      one = one >> 2;
    end
    return root;
  endfunction

  function automatic void score_candidate(input vec_word_t w);
    longint          vx, vy, vz, qx, qy, qz, vn, qn, dot;
    longint unsigned den, score;
    res_word_t       best;
    vx  = longint'(w.vec_x);
    vy  = longint'(w.vec_y);
    vz  = longint'(w.vec_z);
    qx  = longint'(q_x);
    qy  = longint'(q_y);
    qz  = longint'(q_z);
    vn  = vx * vx + vy * vy + vz * vz;
    qn  = qx * qx + qy * qy + qz * qz;
    dot = vx * qx + vy * qy + vz * qz;
    if (run_len >= MAX_VECTORS) begin
      run_overflow = 1'b1;
    end else begin
      if (vn != 0 && qn != 0 && dot > 0) begin
        den = floor_sqrt(64'(vn) * 64'(qn));
        if (den == 0) den = 1;
        score = (64'(dot) << 15) / den;
        if (score > 64'(SCORE_MAX)) score = 64'(SCORE_MAX);
        if (score > 64'(run_best_score)) begin
          run_best_score = score[SCORE_W-1:0];
          run_best_idx   = run_len[IDX_W-1:0];
        end
      end
      run_len++;
    end
    if (w.last_vector) begin
      best.best_index = run_best_idx;
      best.best_score = run_best_score;
      best.too_many   = run_overflow;
      pending_best.push_back(best);
      run_len        = 0;
      run_best_idx   = '0;
      run_best_score = '0;
      run_overflow   = 1'b0;
    end
  endfunction

  task automatic check_best(input res_word_t got);
    res_word_t want;
    if (pending_best.size() == 0) begin
      $error("result word with none expected: best_index %0d best_score %0d too_many %0b",
             got.best_index, got.best_score, got.too_many);
      errors++;
    end else begin
      want = pending_best.pop_front();
      if (got.best_index !== want.best_index) begin
        $error("best_index: expected %0d, got %0d", want.best_index, got.best_index);
        errors++;
      end
      if (got.best_score !== want.best_score) begin
        $error("best_score: expected %0d, got %0d", want.best_score, got.best_score);
        errors++;
      end
      if (got.too_many !== want.too_many) begin
        $error("too_many: expected %0b, got %0b", want.too_many, got.too_many);
        errors++;
      end
    end
    results_checked++;
    if (got.too_many === 1'b1) overflow_results++;
    if (got.best_score === SCORE_MAX) saturated_results++;
  endtask

  always @(posedge clk) begin : result_side
    int stall_left;
    if (res_valid && res_ready) begin
      check_best(res_word);
      stall_left = draw_gap(res_idle_on);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    res_ready <= (stall_left == 0) && !hold_on;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cosine_best_match_search_top_test: FAIL");
      $finish;
    end
  end

  task automatic hold_results(input int cycles);
    fork
      begin
        hold_on <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
  endtask

  task automatic send_vec(input vec_word_t w, input bit more);
    repeat (next_gap) @(posedge clk);
    vec_valid <= 1'b1;
    vec_word  <= w;
    @(posedge clk);
    while (!vec_ready) @(posedge clk);
    score_candidate(w);
    words_sent++;
    next_gap = draw_gap(vec_idle_on);
    if (!more && next_gap == 0) next_gap = 1;
    if (next_gap != 0) vec_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_best.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic signed [COMP_W-1:0] value);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= {{(PDATA_W-COMP_W){value[COMP_W-1]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_QUERY_X: q_x = value;
      REG_QUERY_Y: q_y = value;
      REG_QUERY_Z: q_z = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_query(input logic signed [COMP_W-1:0] x, input logic signed [COMP_W-1:0] y,
                           input logic signed [COMP_W-1:0] z);
    wait_drained();
    set_reg(REG_QUERY_X, x);
    set_reg(REG_QUERY_Y, y);
    set_reg(REG_QUERY_Z, z);
    query_settings++;
  endtask

  function automatic logic signed [COMP_W-1:0] clamp16(input int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[COMP_W-1:0];
  endfunction

  function automatic logic signed [COMP_W-1:0] extreme_comp();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic signed [COMP_W-1:0] rand_comp();
    return COMP_W'($urandom_range(0, 65535));
  endfunction

  function automatic int jitter(input int amp);
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  function automatic vec_word_t make_vec(input bit last);
    vec_word_t w;
    int        num, den, amp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        w.vec_x = rand_comp();
        w.vec_y = rand_comp();
        w.vec_z = rand_comp();
      end
      4, 5, 6: begin
        num = $urandom_range(1, 4);
        den = $urandom_range(1, 4);
        case ($urandom_range(0, 3))
          0: amp = 0;
          1: amp = 4;
          2: amp = 64;
          default: amp = 2048;
        endcase
        w.vec_x = clamp16(int'(q_x) * num / den + jitter(amp));
        w.vec_y = clamp16(int'(q_y) * num / den + jitter(amp));
        w.vec_z = clamp16(int'(q_z) * num / den + jitter(amp));
      end
      7: begin
        w.vec_x = clamp16(jitter(3));
        w.vec_y = clamp16(jitter(3));
        w.vec_z = clamp16(jitter(3));
      end
      8: begin
        w.vec_x = '0;
        w.vec_y = '0;
        w.vec_z = '0;
      end
      default: begin
        w.vec_x = extreme_comp();
        w.vec_y = extreme_comp();
        w.vec_z = extreme_comp();
      end
    endcase
    w.last_vector = last;
    return w;
  endfunction

  function automatic logic signed [COMP_W-1:0] rand_query_comp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return extreme_comp();
      2: return clamp16(jitter(8));
      default: return rand_comp();
    endcase
  endfunction

  task automatic set_random_query();
    set_query(rand_query_comp(), rand_query_comp(), rand_query_comp());
  endtask

  function automatic vec_word_t vec(input int x, input int y, input int z, input bit last);
    vec_word_t w;
    w.vec_x       = x[COMP_W-1:0];
    w.vec_y       = y[COMP_W-1:0];
    w.vec_z       = z[COMP_W-1:0];
    w.last_vector = last;
    return w;
  endfunction

  task automatic send_runs(input int n_words);
    int left, len;
    left = n_words;
    while (left > 0) begin
      len = ($urandom_range(0, 5) == 0) ? 1 : int'($urandom_range(1, 24));
      if (len > left) len = left;
      vec_idle_on = ($urandom_range(0, 3) != 0);
      res_idle_on <= ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++)
        send_vec(make_vec(i == len - 1), !(i == len - 1 && len == left));
      left -= len;
    end
  endtask

  task automatic test_reset_query();
    send_vec(vec(1000, 2000, 3000, 0), 1'b1);
    send_vec(vec(-5, 7, 32767, 1), 1'b0);
  endtask

  task automatic test_score_extremes();
    set_query(16'h8000, 16'h8000, 16'h8000);
    send_vec(vec(32767, 32767, 32767, 0), 1'b1);
    send_vec(vec(0, 0, 0, 0), 1'b1);
    send_vec(vec(-32768, -32768, -32768, 0), 1'b1);
    send_vec(vec(-1, -1, -1, 0), 1'b1);
    send_vec(vec(-32768, 0, 0, 1), 1'b0);
  endtask

  task automatic test_first_wins_tie();
    set_query(16'sd0, 16'sd32767, 16'sd0);
    send_vec(vec(5, 0, 0, 0), 1'b1);
    send_vec(vec(0, -3, 0, 0), 1'b1);
    send_vec(vec(1, 1, 0, 0), 1'b1);
    send_vec(vec(1, 1, 0, 0), 1'b1);
    send_vec(vec(0, 100, 0, 0), 1'b1);
    send_vec(vec(0, 100, 1, 0), 1'b1);
    send_vec(vec(0, 7, 0, 1), 1'b0);
  endtask

  task automatic test_single_word_runs();
    set_query(16'sd32767, 16'sd32767, 16'sd32767);
    send_vec(vec(32767, 32767, 32767, 1), 1'b1);
    send_vec(vec(0, 0, 0, 1), 1'b1);
    send_vec(vec(-2, 1, 0, 0), 1'b1);
    send_vec(vec(3, 2, 1, 1), 1'b0);
  endtask

  task automatic test_random_runs();
    set_random_query();
    send_runs(250);
  endtask

  task automatic test_query_sweep();
    set_query(16'sd32767, 16'sd32767, 16'sd32767);
    send_runs(40);
    set_query(16'h8000, 16'h8000, 16'h8000);
    send_runs(40);
    set_query(16'sd0, 16'sd0, 16'sd0);
    send_runs(40);
    set_query(16'sd0, 16'sd0, -16'sd1);
    send_runs(40);
    set_query(16'sd32767, 16'h8000, 16'sd1);
    send_runs(40);
    set_random_query();
    send_runs(40);
    set_random_query();
    send_runs(40);
  endtask

  task automatic test_full_run();
    int len;
    set_random_query();
    len = MAX_VECTORS + int'($urandom_range(1, 3));
    for (int i = 0; i < len; i++) begin
      if (i % 100 == 0) begin
        vec_idle_on = ($urandom_range(0, 1) != 0);
        res_idle_on <= ($urandom_range(0, 1) != 0);
      end
      send_vec(make_vec(i == len - 1), i != len - 1);
    end
  endtask

  task automatic test_output_stall();
    set_random_query();
    vec_idle_on = 1'b0;
    hold_results(900);
    for (int i = 0; i < 12; i++) send_vec(make_vec(1'b1), 1'b1);
    send_runs(30);
  endtask

  task automatic test_drain_pause();
    set_random_query();
    send_runs(20);
    wait_drained();
    send_runs(20);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_query();
    test_score_extremes();
    test_first_wins_tie();
    test_single_word_runs();
    test_random_runs();
    test_query_sweep();
    test_full_run();
    test_output_stall();
    test_drain_pause();
    wait_drained();
    $display("sent %0d candidate words under %0d query settings, %0d results checked",
             words_sent, query_settings, results_checked);
    $display("%0d results from overflowed runs, %0d with a saturated score",
             overflow_results, saturated_results);
    if (errors == 0) begin
      $display("cosine_best_match_search_top_test: PASS");
    end else begin
      $display("cosine_best_match_search_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== cosine_best_match_search_top.f =====
+incdir+hw/rtl
hw/rtl/cbms_pkg.sv
hw/rtl/cbms_ctrl.sv
hw/rtl/cbms_dp.sv
hw/rtl/cosine_best_match_search_top.sv
tb/cosine_best_match_search_top_test.sv
